// ===== hdl/mtcb_pkg.sv =====
`default_nettype none

package mtcb_pkg;

   // Register indexes on the CSR port (byte address = 4 * index)
   localparam int unsigned REG_W = 3;
   localparam logic [REG_W-1:0] REG_FIRST_COLOR  = 3'd0;
   localparam logic [REG_W-1:0] REG_SECOND_COLOR = 3'd1;
   localparam logic [REG_W-1:0] REG_FIRST_WIDTH  = 3'd2;
   localparam logic [REG_W-1:0] REG_SECOND_WIDTH = 3'd3;
   localparam logic [REG_W-1:0] REG_FADE_LENGTH  = 3'd4;
   localparam logic [REG_W-1:0] REG_LED_COUNT    = 3'd5;

   // Reset values of the registers
   localparam logic [23:0] RST_FIRST_COLOR  = 24'hFF0A0A;
   localparam logic [23:0] RST_SECOND_COLOR = 24'h323232;
   localparam logic [7:0]  RST_FIRST_WIDTH  = 8'd7;
   localparam logic [7:0]  RST_SECOND_WIDTH = 8'd7;
   localparam logic [5:0]  RST_FADE_LENGTH  = 6'd3;
   localparam logic [6:0]  RST_LED_COUNT    = 7'd64;

   // Step addresses of the control program
   localparam int unsigned PC_W = 3;
   localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
   localparam logic [PC_W-1:0] PC_MOD_INIT = 3'd1;
   localparam logic [PC_W-1:0] PC_MOD_STEP = 3'd2;
   localparam logic [PC_W-1:0] PC_SET_POS  = 3'd3;
   localparam logic [PC_W-1:0] PC_CLASSIFY = 3'd4;
   localparam logic [PC_W-1:0] PC_DIV_STEP = 3'd5;
   localparam logic [PC_W-1:0] PC_EMIT     = 3'd6;
   localparam logic [PC_W-1:0] PC_DONE     = 3'd7;

   // Datapath operations
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_MOD_INIT = 3'd1;
   localparam logic [2:0] OP_MOD_STEP = 3'd2;
   localparam logic [2:0] OP_SET_POS  = 3'd3;
   localparam logic [2:0] OP_CLASSIFY = 3'd4;
   localparam logic [2:0] OP_DIV_STEP = 3'd5;
   localparam logic [2:0] OP_EMIT     = 3'd6;

   // Jump conditions
   localparam logic [2:0] C_NEVER    = 3'd0;
   localparam logic [2:0] C_ALWAYS   = 3'd1;
   localparam logic [2:0] C_NO_START = 3'd2;
   localparam logic [2:0] C_CNT_NZ   = 3'd3;
   localparam logic [2:0] C_NO_LEDS  = 3'd4;
   localparam logic [2:0] C_SOLID    = 3'd5;
   localparam logic [2:0] C_NOT_LAST = 3'd6;

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic            wait_out;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w.op       = OP_NONE;
      w.cond     = C_ALWAYS;
      w.wait_out = 1'b0;
      w.target   = PC_IDLE;
      unique case (pc)
         PC_IDLE: begin
            w.cond = C_NO_START;
         end
         PC_MOD_INIT: begin
            w.op   = OP_MOD_INIT;
            w.cond = C_NEVER;
         end
         PC_MOD_STEP: begin
            w.op     = OP_MOD_STEP;
            w.cond   = C_CNT_NZ;
            w.target = PC_MOD_STEP;
         end
         PC_SET_POS: begin
            w.op   = OP_SET_POS;
            w.cond = C_NO_LEDS;
         end
         PC_CLASSIFY: begin
            w.op     = OP_CLASSIFY;
            w.cond   = C_SOLID;
            w.target = PC_EMIT;
         end
         PC_DIV_STEP: begin
            w.op     = OP_DIV_STEP;
            w.cond   = C_CNT_NZ;
            w.target = PC_DIV_STEP;
         end
         PC_EMIT: begin
            w.op       = OP_EMIT;
            w.cond     = C_NOT_LAST;
            w.wait_out = 1'b1;
            w.target   = PC_CLASSIFY;
         end
         PC_DONE: begin
            w.cond = C_ALWAYS;
         end
         default: begin
            w.cond = C_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/moving_two_color_band.sv =====
// Moving two-color band renderer. Each accepted request word with frame_request set
// renders one frame: one word per LED (index, red, green, blue, last flag), LED 0 first,
// the final one flagged; a request word with frame_request clear is taken and dropped.
// A small microcode program drives the datapath: each frame starts with a setup pass (an
// 11-step shift-subtract reduction of the phase modulo the band period); an LED in a solid
// zone is then emitted directly, while in a blend zone the three channels of an LED go
// through an 8-step restoring divider in parallel; result-side stalls hold the emit step.
// A new request is taken only when the previous frame has been fully issued. CSR writes
// are expected only between frames.
`default_nettype none

module moving_two_color_band #(
   parameter int unsigned MAX_LEDS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_frame_request,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_led_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_last_of_frame,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ---------------- CSR registers ----------------
   logic [23:0] color1_ff, color2_ff;
   logic [7:0]  width1_ff, width2_ff;
   logic [5:0]  fade_ff;
   logic [6:0]  led_count_ff;
   logic                           csr_wr;
   logic [mtcb_pkg::REG_W-1:0]     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         color1_ff    <= mtcb_pkg::RST_FIRST_COLOR;
         color2_ff    <= mtcb_pkg::RST_SECOND_COLOR;
         width1_ff    <= mtcb_pkg::RST_FIRST_WIDTH;
         width2_ff    <= mtcb_pkg::RST_SECOND_WIDTH;
         fade_ff      <= mtcb_pkg::RST_FADE_LENGTH;
         led_count_ff <= mtcb_pkg::RST_LED_COUNT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            mtcb_pkg::REG_FIRST_COLOR:  color1_ff    <= csr_pwdata[23:0];
            mtcb_pkg::REG_SECOND_COLOR: color2_ff    <= csr_pwdata[23:0];
            mtcb_pkg::REG_FIRST_WIDTH:  width1_ff    <= csr_pwdata[7:0];
            mtcb_pkg::REG_SECOND_WIDTH: width2_ff    <= csr_pwdata[7:0];
            mtcb_pkg::REG_FADE_LENGTH:  fade_ff      <= csr_pwdata[5:0];
            mtcb_pkg::REG_LED_COUNT:    led_count_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         mtcb_pkg::REG_FIRST_COLOR:  csr_prdata = {8'd0, color1_ff};
         mtcb_pkg::REG_SECOND_COLOR: csr_prdata = {8'd0, color2_ff};
         mtcb_pkg::REG_FIRST_WIDTH:  csr_prdata = {24'd0, width1_ff};
         mtcb_pkg::REG_SECOND_WIDTH: csr_prdata = {24'd0, width2_ff};
         mtcb_pkg::REG_FADE_LENGTH:  csr_prdata = {26'd0, fade_ff};
         mtcb_pkg::REG_LED_COUNT:    csr_prdata = {25'd0, led_count_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- band geometry ----------------
   logic [9:0] period;
   logic       period_zero;
   logic [6:0] n_sat;
   logic [6:0] max_leds;

   assign period      = 10'(width1_ff) + 10'(width2_ff) + {3'd0, fade_ff, 1'b0};
   assign period_zero = (period == 10'd0);
   assign max_leds    = 7'(MAX_LEDS);
   assign n_sat       = (led_count_ff > max_leds) ? max_leds : led_count_ff;

   // ---------------- datapath registers ----------------
   logic [mtcb_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [10:0] rem_ff, rem_in;
   logic [10:0] dvd_ff, dvd_in;
   logic [9:0]  phase_ff, phase_in;
   logic [9:0]  pos_ff, pos_in;
   logic [6:0]  led_ff, led_in;
   logic [6:0]  n_ff, n_in;
   logic [13:0] dsh_ff, dsh_in;
   logic [13:0] num_ff [3];
   logic [13:0] num_in [3];
   logic [7:0]  quo_ff [3];
   logic [7:0]  quo_in [3];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic [7:0]  rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;
   logic        rsp_last_ff, rsp_last_in;

   // ---------------- position classification ----------------
   logic [9:0]  lim1, lim2, lim3;
   logic        in_c1, in_f1, in_c2, solid;
   logic [5:0]  step_k;
   logic [6:0]  div_d, div_dk;
   logic [23:0] solid_color, blend_a, blend_b;
   logic [14:0] prod_a [3];
   logic [14:0] prod_b [3];

   assign lim1   = 10'(width1_ff);
   assign lim2   = lim1 + 10'(fade_ff);
   assign lim3   = lim2 + 10'(width2_ff);
   assign in_c1  = (pos_ff <= lim1);
   assign in_f1  = (pos_ff <= lim2);
   assign in_c2  = (pos_ff <= lim3);
   assign solid  = in_c1 || (!in_f1 && in_c2);
   assign step_k = in_f1 ? 6'(pos_ff - lim1) : 6'(pos_ff - lim3);
   assign div_d  = 7'(fade_ff) + 7'd1;
   assign div_dk = div_d - 7'(step_k);
   assign solid_color = in_c1 ? color1_ff : color2_ff;
   assign blend_a     = in_f1 ? color1_ff : color2_ff;
   assign blend_b     = in_f1 ? color2_ff : color1_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_a[j] = 15'(blend_a[23-8*j -: 8]) * 15'(div_dk);
         prod_b[j] = 15'(blend_b[23-8*j -: 8]) * 15'(step_k);
      end
   end

   // ---------------- sequencer ----------------
   mtcb_pkg::ctrl_word_type cw;
   logic       hold, jump, last_led;
   logic [10:0] rem_sh;
   logic        rem_ge;
   logic [9:0]  pos_start, pos_inc;

   assign cw       = mtcb_pkg::ucode_rom(pc_ff);
   assign hold     = cw.wait_out && rsp_valid_ff && rsp_stall;
   assign last_led = ((led_ff + 7'd1) == n_ff);
   assign req_stall = (pc_ff != mtcb_pkg::PC_IDLE);

   assign rem_sh    = {rem_ff[9:0], dvd_ff[10]};
   assign rem_ge    = (rem_sh >= {1'b0, period});
   assign pos_start = period_zero ? 10'd0 : rem_ff[9:0];
   assign pos_inc   = pos_ff + 10'd1;

   always_comb begin
      unique case (cw.cond)
         mtcb_pkg::C_NEVER:    jump = 1'b0;
         mtcb_pkg::C_ALWAYS:   jump = 1'b1;
         mtcb_pkg::C_NO_START: jump = !(req_valid && req_frame_request);
         mtcb_pkg::C_CNT_NZ:   jump = (cnt_ff != 4'd0);
         mtcb_pkg::C_NO_LEDS:  jump = (n_sat == 7'd0);
         mtcb_pkg::C_SOLID:    jump = solid;
         mtcb_pkg::C_NOT_LAST: jump = !last_led;
         default:              jump = 1'b1;
      endcase
   end

   always_comb begin
      pc_in    = hold ? pc_ff : (jump ? cw.target : pc_ff + mtcb_pkg::PC_W'(1));
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      led_in   = led_ff;
      n_in     = n_ff;
      dsh_in   = dsh_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;

      // drop the output word once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_last_in  = rsp_last_ff;

      if (!hold) begin
         unique case (cw.op)
            mtcb_pkg::OP_NONE: ;
            mtcb_pkg::OP_MOD_INIT: begin
               rem_in = 11'd0;
               dvd_in = 11'(phase_ff) + 11'd1;
               cnt_in = 4'd10;
            end
            mtcb_pkg::OP_MOD_STEP: begin
               rem_in = rem_ge ? rem_sh - {1'b0, period} : rem_sh;
               dvd_in = {dvd_ff[9:0], 1'b0};
               cnt_in = cnt_ff - 4'd1;
            end
            mtcb_pkg::OP_SET_POS: begin
               // (phase + 1) mod P is both LED 0's position and the next phase
               pos_in   = pos_start;
               phase_in = pos_start;
               led_in   = 7'd0;
               n_in     = n_sat;
            end
            mtcb_pkg::OP_CLASSIFY: begin
               if (solid) begin
                  for (int j = 0; j < 3; j++) quo_in[j] = solid_color[23-8*j -: 8];
               end else begin
                  for (int j = 0; j < 3; j++) num_in[j] = 14'(prod_a[j] + prod_b[j]);
                  dsh_in = {div_d, 7'd0};
                  cnt_in = 4'd7;
               end
            end
            mtcb_pkg::OP_DIV_STEP: begin
               for (int j = 0; j < 3; j++) begin
                  if (num_ff[j] >= dsh_ff) begin
                     num_in[j] = num_ff[j] - dsh_ff;
                     quo_in[j] = {quo_ff[j][6:0], 1'b1};
                  end else begin
                     quo_in[j] = {quo_ff[j][6:0], 1'b0};
                  end
               end
               dsh_in = {1'b0, dsh_ff[13:1]};
               cnt_in = cnt_ff - 4'd1;
            end
            mtcb_pkg::OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = led_ff[5:0];
               rsp_r_in     = quo_ff[0];
               rsp_g_in     = quo_ff[1];
               rsp_b_in     = quo_ff[2];
               rsp_last_in  = last_led;
               led_in       = led_ff + 7'd1;
               pos_in       = (period_zero || pos_inc == period) ? 10'd0 : pos_inc;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= mtcb_pkg::PC_IDLE;
         phase_ff     <= 10'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      pos_ff      <= pos_in;
      led_ff      <= led_in;
      n_ff        <= n_in;
      dsh_ff      <= dsh_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_index     = rsp_idx_ff;
   assign rsp_red           = rsp_r_ff;
   assign rsp_green         = rsp_g_ff;
   assign rsp_blue          = rsp_b_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/mtcb_checker.sv =====
`default_nettype none

module mtcb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [5:0] rsp_led_index,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic       rsp_last_of_frame
);

   logic       rsp_acc;
   logic       have_ff;
   logic       prev_last_ff;
   logic [5:0] prev_idx_ff;

   assign rsp_acc = rsp_valid && !rsp_stall;

   // track the last word taken on the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         prev_last_ff <= 1'b0;
         prev_idx_ff  <= 6'd0;
      end else if (rsp_acc) begin
         have_ff      <= 1'b1;
         prev_last_ff <= rsp_last_of_frame;
         prev_idx_ff  <= rsp_led_index;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_index) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_last_of_frame))
      else $error("result word changed while stalled");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && (!have_ff || prev_last_ff) |-> rsp_led_index == 6'd0)
      else $error("frame does not start at LED 0");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && have_ff && !prev_last_ff |-> rsp_led_index == prev_idx_ff + 6'd1)
      else $error("LED index skipped or repeated");

   a_busy_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_last_of_frame |=> req_stall)
      else $error("request taken in the middle of a frame");

endmodule

bind moving_two_color_band mtcb_checker u_mtcb_checker (.*);

`default_nettype wire
